/* hw/rtl/pmrc_pkg.sv */
// Shared types and register indexes for the measure range clipper.
package pmrc_pkg;

  localparam int unsigned COORD_BITS = 32;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_HIGH = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_ISSUE,
    S_WAIT,
    S_COPY,
    S_DECIDE,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN
  } lerp_state_t;

endpackage

/* hw/rtl/pmrc_if.sv */
// Stream interfaces: vertex input, point output and configuration writes.
interface pmrc_vtx_if #(parameter int unsigned W = pmrc_pkg::COORD_BITS);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vx;
  logic signed [W-1:0] vy;
  logic signed [W-1:0] vz;
  logic signed [W-1:0] vm;
  logic                line_end;
  modport source (output valid, vx, vy, vz, vm, line_end, input ready);
  modport sink   (input valid, vx, vy, vz, vm, line_end, output ready);
endinterface

interface pmrc_pt_if #(parameter int unsigned W = pmrc_pkg::COORD_BITS);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] ox;
  logic signed [W-1:0] oy;
  logic signed [W-1:0] oz;
  logic signed [W-1:0] om;
  logic                part_first;
  logic                part_last;
  logic                run_last;
  modport source (output valid, ox, oy, oz, om, part_first, part_last, run_last,
                  input ready);
  modport sink   (input valid, ox, oy, oz, om, part_first, part_last, run_last,
                  output ready);
endinterface

interface pmrc_cfg_if #(parameter int unsigned W = pmrc_pkg::COORD_BITS);
  logic                             valid;
  logic                             ready;
  logic [pmrc_pkg::CFG_IDX_W-1:0]   index;
  logic [W-1:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/polyline_measure_range_clipper_unit.sv */
// Measure range clipper for measured polylines, top level.
//
// vin takes one vertex per beat (x, y, z, m, line_end); pout gives the
// clipped points, at most two per vertex, with part_first / part_last
// marking parts and run_last on the last point a vertex causes. cfg writes
// measure_low (index 0) and measure_high (index 1); it is always ready and
// must only be used while the block is idle.
// One vertex is handled at a time; vin.ready is high only when idle.
// Each interpolated coordinate runs through one shared bit-serial
// multiply/divide unit, three coordinates per clipped end.
// A finished point waits in the output register while pout stalls; the
// block does not take the next vertex until its last point sits in the
// output register.
// Reset (rst, synchronous) clears the window to zero, closes any part and
// marks the next vertex as the start of a new line.
module polyline_measure_range_clipper_unit (
  input logic          clk,
  input logic          rst,
  pmrc_vtx_if.sink     vin,
  pmrc_pt_if.source    pout,
  pmrc_cfg_if.sink     cfg
);

  localparam int unsigned W = pmrc_pkg::COORD_BITS;

  pmrc_pkg::state_t state, state_next;

  logic signed [W-1:0] mlo, mhi;
  logic signed [W-1:0] cur [4];
  logic signed [W-1:0] prev [4];
  logic signed [W-1:0] last [4];
  logic signed [W-1:0] p0 [4];
  logic signed [W-1:0] q0 [4];
  logic signed [W-1:0] pp [4];
  logic signed [W-1:0] pq [4];
  logic                cur_end;
  logic                part_open;
  logic                awaiting;

  logic                sw, hit, need_hi, collapse, pmod, qmod;
  logic [W-1:0]        den, num_lo, num_hi;
  logic                side;
  logic [1:0]          k;

  logic signed [W-1:0] res_c [2][4];
  logic                res_f [2];
  logic                res_l [2];
  logic [1:0]          nres;
  logic                idx;

  logic                out_valid;
  logic signed [W-1:0] o_x, o_y, o_z, o_m;
  logic                o_f, o_l, o_r;

  // setup decisions
  logic                c_sw, c_eq, c_wv, c_hit, c_clip;
  logic                c_need_lo, c_need_hi, c_collapse;
  logic signed [W-1:0] c_pm, c_qm;

  // lerp
  logic                lerp_start, lerp_busy, lerp_done;
  logic signed [W-1:0] lerp_from, lerp_to, lerp_res;
  logic [W-1:0]        lerp_num;

  // decide
  logic signed [W-1:0] da [4];
  logic signed [W-1:0] db [4];
  logic signed [W-1:0] eff_last [4];
  logic                bmod, closing, opened, dup;
  logic [1:0]          d_n;
  logic signed [W-1:0] d_c [2][4];
  logic                d_f [2];
  logic                d_l [2];
  logic                d_open;
  logic                out_load;

  assign cfg.ready = 1'b1;

  always_comb begin
    c_sw       = prev[3] > cur[3];
    c_eq       = prev[3] == cur[3];
    c_pm       = c_sw ? cur[3] : prev[3];
    c_qm       = c_sw ? prev[3] : cur[3];
    c_wv       = mlo <= mhi;
    c_hit      = c_wv && (c_eq ? !(c_pm < mlo || c_pm > mhi)
                               : !(c_qm < mlo || c_pm > mhi));
    c_clip     = c_hit && !c_eq && !(c_pm >= mlo && c_qm <= mhi);
    c_need_lo  = c_clip && c_pm < mlo;
    c_collapse = c_clip && mlo == mhi;
    c_need_hi  = c_clip && !c_collapse && c_qm > mhi;
  end

  always_comb begin
    lerp_from = side ? q0[k] : p0[k];
    lerp_to   = side ? p0[k] : q0[k];
    lerp_num  = side ? num_hi : num_lo;
  end

  pmrc_lerp #(.W(W)) u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (lerp_start),
    .from  (lerp_from),
    .to    (lerp_to),
    .num   (lerp_num),
    .den   (den),
    .busy  (lerp_busy),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  always_comb begin
    bmod    = sw ? pmod : qmod;
    closing = bmod || cur_end;
    opened  = !part_open;
    for (int i = 0; i < 4; i++) begin
      da[i]       = sw ? pq[i] : pp[i];
      db[i]       = sw ? pp[i] : pq[i];
      eff_last[i] = opened ? da[i] : last[i];
    end
    dup = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (db[i] != eff_last[i]) dup = 1'b0;
    end
    d_n    = 2'd0;
    d_open = part_open;
    for (int j = 0; j < 2; j++) begin
      d_f[j] = 1'b0;
      d_l[j] = 1'b0;
      for (int i = 0; i < 4; i++) d_c[j][i] = last[i];
    end
    if (!hit) begin
      if (part_open) begin
        d_n    = 2'd1;
        d_l[0] = 1'b1;
        d_open = 1'b0;
      end
    end else begin
      if (opened) begin
        d_n    = 2'd1;
        d_f[0] = 1'b1;
        for (int i = 0; i < 4; i++) d_c[0][i] = da[i];
      end
      if (dup) begin
        if (closing) begin
          if (opened) begin
            d_l[0] = 1'b1;
          end else begin
            d_n    = 2'd1;
            d_l[0] = 1'b1;
          end
        end
      end else begin
        d_l[d_n[0]] = closing;
        for (int i = 0; i < 4; i++) d_c[d_n[0]][i] = db[i];
        d_n = d_n + 2'd1;
      end
      d_open = !closing;
    end
  end

  assign out_load = (state == pmrc_pkg::S_SEND) && (!out_valid || pout.ready);

  always_comb begin
    state_next = state;
    case (state)
      pmrc_pkg::S_IDLE: if (vin.valid) state_next = pmrc_pkg::S_SETUP;
      pmrc_pkg::S_SETUP: begin
        if (awaiting) state_next = pmrc_pkg::S_IDLE;
        else if (c_need_lo || c_need_hi) state_next = pmrc_pkg::S_ISSUE;
        else if (c_collapse) state_next = pmrc_pkg::S_COPY;
        else state_next = pmrc_pkg::S_DECIDE;
      end
      pmrc_pkg::S_ISSUE: state_next = pmrc_pkg::S_WAIT;
      pmrc_pkg::S_WAIT: begin
        if (lerp_done) begin
          if (k != 2'd2) state_next = pmrc_pkg::S_ISSUE;
          else if (!side && collapse) state_next = pmrc_pkg::S_COPY;
          else if (!side && need_hi) state_next = pmrc_pkg::S_ISSUE;
          else state_next = pmrc_pkg::S_DECIDE;
        end
      end
      pmrc_pkg::S_COPY: state_next = pmrc_pkg::S_DECIDE;
      pmrc_pkg::S_DECIDE: begin
        if (d_n == 2'd0) state_next = pmrc_pkg::S_IDLE;
        else state_next = pmrc_pkg::S_SEND;
      end
      pmrc_pkg::S_SEND: begin
        if (out_load && {1'b0, idx} == nres - 2'd1) state_next = pmrc_pkg::S_IDLE;
      end
      default: state_next = pmrc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    vin.ready  = state == pmrc_pkg::S_IDLE;
    lerp_start = state == pmrc_pkg::S_ISSUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pmrc_pkg::S_IDLE;
      mlo       <= '0;
      mhi       <= '0;
      part_open <= 1'b0;
      awaiting  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          pmrc_pkg::REG_MEASURE_LOW:  mlo <= $signed(cfg.data);
          pmrc_pkg::REG_MEASURE_HIGH: mhi <= $signed(cfg.data);
          default: ;
        endcase
      end
      if (state == pmrc_pkg::S_SETUP && awaiting) awaiting <= cur_end;
      if (state == pmrc_pkg::S_DECIDE) begin
        part_open <= d_open;
        awaiting  <= cur_end;
      end
      if (out_load) out_valid <= 1'b1;
      else if (pout.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pmrc_pkg::S_IDLE: begin
        if (vin.valid) begin
          cur[0]  <= vin.vx;
          cur[1]  <= vin.vy;
          cur[2]  <= vin.vz;
          cur[3]  <= vin.vm;
          cur_end <= vin.line_end;
        end
      end
      pmrc_pkg::S_SETUP: begin
        sw       <= c_sw;
        hit      <= c_hit;
        need_hi  <= c_need_hi;
        collapse <= c_collapse;
        pmod     <= c_need_lo;
        qmod     <= c_need_hi || c_collapse;
        den      <= W'(c_qm - c_pm);
        num_lo   <= W'(mlo - c_pm);
        num_hi   <= W'(c_qm - mhi);
        side     <= !c_need_lo;
        k        <= 2'd0;
        for (int i = 0; i < 4; i++) begin
          p0[i] <= c_sw ? cur[i] : prev[i];
          q0[i] <= c_sw ? prev[i] : cur[i];
          pp[i] <= c_sw ? cur[i] : prev[i];
          pq[i] <= c_sw ? prev[i] : cur[i];
        end
        if (c_need_lo) pp[3] <= mlo;
        if (c_need_hi) pq[3] <= mhi;
        if (awaiting) begin
          for (int i = 0; i < 4; i++) prev[i] <= cur[i];
        end
      end
      pmrc_pkg::S_WAIT: begin
        if (lerp_done) begin
          if (side) pq[k] <= lerp_res;
          else pp[k] <= lerp_res;
          if (k == 2'd2) begin
            k    <= 2'd0;
            side <= 1'b1;
          end else begin
            k <= k + 2'd1;
          end
        end
      end
      pmrc_pkg::S_COPY: begin
        for (int i = 0; i < 4; i++) pq[i] <= pp[i];
      end
      pmrc_pkg::S_DECIDE: begin
        nres <= d_n;
        idx  <= 1'b0;
        for (int j = 0; j < 2; j++) begin
          res_f[j] <= d_f[j];
          res_l[j] <= d_l[j];
          for (int i = 0; i < 4; i++) res_c[j][i] <= d_c[j][i];
        end
        for (int i = 0; i < 4; i++) prev[i] <= cur[i];
        if (hit && !dup) begin
          for (int i = 0; i < 4; i++) last[i] <= db[i];
        end else if (hit && opened) begin
          for (int i = 0; i < 4; i++) last[i] <= da[i];
        end
      end
      pmrc_pkg::S_SEND: begin
        if (out_load) begin
          o_x <= res_c[idx][0];
          o_y <= res_c[idx][1];
          o_z <= res_c[idx][2];
          o_m <= res_c[idx][3];
          o_f <= res_f[idx];
          o_l <= res_l[idx];
          o_r <= {1'b0, idx} == nres - 2'd1;
          idx <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pout.valid      = out_valid;
  assign pout.ox         = o_x;
  assign pout.oy         = o_y;
  assign pout.oz         = o_z;
  assign pout.om         = o_m;
  assign pout.part_first = o_f;
  assign pout.part_last  = o_l;
  assign pout.run_last   = o_r;

  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    vin.valid && vin.ready |=> state == pmrc_pkg::S_SETUP)
    else $error("accepted beat not followed by setup");

  a_lerp_idle: assert property (@(posedge clk) disable iff (rst)
    state == pmrc_pkg::S_IDLE |-> !lerp_busy)
    else $error("interpolator busy while idle");

  a_send_count: assert property (@(posedge clk) disable iff (rst)
    state == pmrc_pkg::S_SEND |-> nres != 2'd0)
    else $error("send with no pending points");

endmodule

/* hw/rtl/pmrc_lerp.sv */
// Bit-serial interpolator: from + round((to - from) * num / den).
module pmrc_lerp #(
  parameter int unsigned W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] from,
  input  logic signed [W-1:0] to,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output logic                busy,
  output logic                done,
  output logic signed [W-1:0] res
);

  localparam int unsigned CW = $clog2(W);

  pmrc_pkg::lerp_state_t state, state_next;

  logic [CW-1:0]       cnt;
  logic [W-1:0]        hi;
  logic [W-1:0]        lo;
  logic [W-1:0]        mag;
  logic [W-1:0]        dv;
  logic                neg;
  logic signed [W-1:0] base;

  logic signed [W:0]   diff;
  logic [W:0]          diff_neg;
  logic [W:0]          mul_sum;
  logic [W:0]          rem_sh;
  logic                ge;
  logic                rnd;
  logic [W-1:0]        qr;
  logic                cnt_end;

  always_comb begin
    diff     = {to[W-1], to} - {from[W-1], from};
    diff_neg = -diff;
    mul_sum  = {1'b0, hi} + (lo[0] ? {1'b0, mag} : {(W+1){1'b0}});
    rem_sh   = {hi, lo[W-1]};
    ge       = rem_sh >= {1'b0, dv};
    rnd      = {hi, 1'b0} >= {1'b0, dv};
    qr       = lo + {{(W-1){1'b0}}, rnd};
    cnt_end  = cnt == CW'(W-1);
  end

  always_comb begin
    state_next = state;
    case (state)
      pmrc_pkg::L_IDLE: if (start) state_next = pmrc_pkg::L_MUL;
      pmrc_pkg::L_MUL:  if (cnt_end) state_next = pmrc_pkg::L_DIV;
      pmrc_pkg::L_DIV:  if (cnt_end) state_next = pmrc_pkg::L_FIN;
      pmrc_pkg::L_FIN:  state_next = pmrc_pkg::L_IDLE;
      default:          state_next = pmrc_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    busy = state != pmrc_pkg::L_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmrc_pkg::L_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      done  <= state == pmrc_pkg::L_FIN;
      if (state == pmrc_pkg::L_IDLE || cnt_end) cnt <= '0;
      else cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pmrc_pkg::L_IDLE: begin
        if (start) begin
          neg  <= diff[W];
          mag  <= diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
          dv   <= den;
          base <= from;
          hi   <= '0;
          lo   <= num;
        end
      end
      pmrc_pkg::L_MUL: begin
        hi <= mul_sum[W:1];
        lo <= {mul_sum[0], lo[W-1:1]};
      end
      pmrc_pkg::L_DIV: begin
        hi <= ge ? W'(rem_sh - {1'b0, dv}) : rem_sh[W-1:0];
        lo <= {lo[W-2:0], ge};
      end
      pmrc_pkg::L_FIN: begin
        res <= neg ? base - $signed(qr) : base + $signed(qr);
      end
      default: ;
    endcase
  end

endmodule

/* verif/pmrc_tb_if.sv */
// Testbench-side note: interfaces come from the RTL file pmrc_if.sv; this file holds shared tb types.
package pmrc_tb_pkg;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] m;
    logic               le;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] m;
    logic               pf;
    logic               pl;
    logic               rl;
  } point_t;
endpackage

/* verif/tb_polyline_measure_range_clipper_unit.sv */
// Testbench for the measure range clipper: random polylines, clip prediction, scoreboard.
module tb_polyline_measure_range_clipper_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pmrc_vtx_if vin();
  pmrc_pt_if  pout();
  pmrc_cfg_if cfg();

  polyline_measure_range_clipper_unit dut (
    .clk(clk), .rst(rst), .vin(vin), .pout(pout), .cfg(cfg)
  );

  pmrc_tb_pkg::vertex_t pending_vtx[$];
  pmrc_tb_pkg::point_t  expected_pts[$];
  int      n_errors = 0;
  int      src_idle_pct = 25;
  int      snk_idle_pct = 84;
  int      hold_cycles = 0;

  longint win_lo, win_hi;
  longint prv[4];
  longint last_pt[4];
  bit     part_is_open, want_first;

  function automatic longint interp(longint from, longint to, longint num, longint den);
    longint d, mag, q;
    d = to - from;
    mag = d < 0 ? -d : d;
    q = longint'((unsigned'(mag) * unsigned'(num) + unsigned'(den) / 2) / unsigned'(den));
    return d < 0 ? from - q : from + q;
  endfunction

  function automatic void push_pt(longint p[4], bit f, bit l);
    pmrc_tb_pkg::point_t e;
    e.x = p[0][31:0]; e.y = p[1][31:0]; e.z = p[2][31:0]; e.m = p[3][31:0];
    e.pf = f; e.pl = l; e.rl = 0;
    expected_pts.push_back(e);
  endfunction

  task automatic predict_vertex(pmrc_tb_pkg::vertex_t v);
    longint cur[4], a[4], b[4], p0[4], q0[4];
    bit hit, mod_b, sw, closing, opened, same;
    int n0, k;
    longint den;
    cur[0] = v.x; cur[1] = v.y; cur[2] = v.z; cur[3] = v.m;
    n0 = expected_pts.size();
    if (want_first) begin
      prv = cur;
      want_first = v.le;
      return;
    end
    a = prv; b = cur;
    hit = 0; mod_b = 0;
    if (win_lo <= win_hi) begin
      if (a[3] == b[3]) begin
        hit = !(a[3] < win_lo || a[3] > win_hi);
      end else begin
        sw = a[3] > b[3];
        if (sw) begin p0 = b; q0 = a; end else begin p0 = a; q0 = b; end
        if (!(q0[3] < win_lo || p0[3] > win_hi)) begin
          longint pp[4], qq[4];
          bit mp, mq;
          hit = 1; pp = p0; qq = q0; mp = 0; mq = 0;
          den = q0[3] - p0[3];
          if (p0[3] < win_lo) begin
            for (k = 0; k < 3; k++) pp[k] = interp(p0[k], q0[k], win_lo - p0[3], den);
            pp[3] = win_lo; mp = 1;
          end
          if (win_lo == win_hi && (p0[3] < win_lo || q0[3] > win_hi)) begin
            qq = pp; mq = 1;
          end else if (q0[3] > win_hi) begin
            for (k = 0; k < 3; k++) qq[k] = interp(q0[k], p0[k], q0[3] - win_hi, den);
            qq[3] = win_hi; mq = 1;
          end
          if (sw) begin a = qq; b = pp; mod_b = mp; end
          else begin a = pp; b = qq; mod_b = mq; end
        end
      end
    end
    if (!hit) begin
      if (part_is_open) begin
        push_pt(last_pt, 0, 1);
        part_is_open = 0;
      end
    end else begin
      closing = mod_b || v.le;
      opened = 0;
      if (!part_is_open) begin
        push_pt(a, 1, 0);
        last_pt = a; part_is_open = 1; opened = 1;
      end
      same = 1;
      for (k = 0; k < 4; k++) if (b[k] != last_pt[k]) same = 0;
      if (same) begin
        if (closing) begin
          if (opened) expected_pts[expected_pts.size()-1].pl = 1;
          else push_pt(last_pt, 0, 1);
        end
      end else begin
        push_pt(b, 0, closing);
        last_pt = b;
      end
      if (closing) part_is_open = 0;
    end
    prv = cur;
    if (v.le) want_first = 1;
    if (expected_pts.size() > n0) expected_pts[expected_pts.size()-1].rl = 1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      vin.valid <= 0;
    end else if (!vin.valid || vin.ready) begin
      if (pending_vtx.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        pmrc_tb_pkg::vertex_t v;
        v = pending_vtx.pop_front();
        vin.vx <= v.x; vin.vy <= v.y; vin.vz <= v.z; vin.vm <= v.m;
        vin.line_end <= v.le;
        vin.valid <= 1;
        predict_vertex(v);
      end else begin
        vin.valid <= 0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) pout.ready <= 0;
    else if (hold_cycles > 0) begin
      pout.ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else pout.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && pout.valid && pout.ready) begin
      if (expected_pts.size() == 0) begin
        $error("unexpected point beat x=%h", pout.ox);
        n_errors++;
      end else begin
        pmrc_tb_pkg::point_t e;
        e = expected_pts.pop_front();
        if (pout.ox !== e.x) begin $error("ox exp %h got %h", e.x, pout.ox); n_errors++; end
        if (pout.oy !== e.y) begin $error("oy exp %h got %h", e.y, pout.oy); n_errors++; end
        if (pout.oz !== e.z) begin $error("oz exp %h got %h", e.z, pout.oz); n_errors++; end
        if (pout.om !== e.m) begin $error("om exp %h got %h", e.m, pout.om); n_errors++; end
        if (pout.part_first !== e.pf) begin
          $error("part_first exp %b got %b", e.pf, pout.part_first); n_errors++;
        end
        if (pout.part_last !== e.pl) begin
          $error("part_last exp %b got %b", e.pl, pout.part_last); n_errors++;
        end
        if (pout.run_last !== e.rl) begin
          $error("run_last exp %b got %b", e.rl, pout.run_last); n_errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_vtx.size() > 0 || vin.valid || expected_pts.size() > 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(logic [pmrc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg.index <= idx; cfg.data <= val; cfg.valid <= 1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    @(posedge clk);
    if (idx == pmrc_pkg::REG_MEASURE_LOW) win_lo = longint'(signed'(val));
    else win_hi = longint'(signed'(val));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near_m(longint c);
    return 32'(c + $signed($urandom_range(400000)) - 200000);
  endfunction

  task automatic queue_line(int nv, bit wild);
    pmrc_tb_pkg::vertex_t v;
    for (int i = 0; i < nv; i++) begin
      v.x = rand_word(); v.y = rand_word(); v.z = rand_word();
      if (wild || $urandom_range(9) == 0) v.m = rand_word();
      else if ($urandom_range(7) == 0 && i > 0) v.m = pending_vtx[$].m;
      else if ($urandom_range(5) == 0) v.m = $urandom_range(1) ? win_lo : win_hi;
      else v.m = near_m((win_lo + win_hi) / 2);
      if ($urandom_range(9) == 0 && i > 0) v.x = pending_vtx[$].x;
      v.le = (i == nv - 1);
      pending_vtx.push_back(v);
    end
  endtask

  task automatic run_phase(int n, logic [31:0] lo, logic [31:0] hi);
    int cnt;
    write_reg(pmrc_pkg::REG_MEASURE_LOW, lo);
    write_reg(pmrc_pkg::REG_MEASURE_HIGH, hi);
    cnt = 0;
    while (cnt < n) begin
      int nv;
      nv = $urandom_range(6, 1);
      queue_line(nv, $urandom_range(9) == 0);
      cnt += nv;
    end
    drain();
  endtask

  initial begin
    pmrc_tb_pkg::vertex_t v;
    win_lo = 0; win_hi = 0; part_is_open = 0; want_first = 1;
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
    vin.valid = 0; vin.vx = 0; vin.vy = 0; vin.vz = 0; vin.vm = 0; vin.line_end = 0;
    pout.ready = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(pmrc_pkg::REG_MEASURE_LOW, 32'h0001_0000);
    write_reg(pmrc_pkg::REG_MEASURE_HIGH, 32'h0005_0000);
    // directed: single vertex, crossings both ways, equal measures, extremes
    v = '{32'h7fff_ffff, 32'h8000_0000, 0, 32'h0003_0000, 1}; pending_vtx.push_back(v);
    v = '{0, 0, 0, 32'h8000_0000, 0}; pending_vtx.push_back(v);
    v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0};
    pending_vtx.push_back(v);
    v = '{5, 5, 5, 32'h0003_0000, 0}; pending_vtx.push_back(v);
    v = '{6, 6, 6, 32'h0003_0000, 0}; pending_vtx.push_back(v);
    v = '{6, 6, 6, 32'h0003_0000, 0}; pending_vtx.push_back(v);
    v = '{9, 9, 9, 32'h0009_0000, 0}; pending_vtx.push_back(v);
    v = '{1, 2, 3, 32'h0009_0000, 1}; pending_vtx.push_back(v);
    v = '{32'h8000_0000, 0, 7, 32'hffff_0000, 0}; pending_vtx.push_back(v);
    v = '{32'h7fff_ffff, 3, 7, 32'h0001_0000, 1}; pending_vtx.push_back(v);
    drain();
    // window change inside an open part, then out of range closes it
    v = '{1, 1, 1, 32'h0002_0000, 0}; pending_vtx.push_back(v);
    v = '{2, 2, 2, 32'h0003_0000, 0}; pending_vtx.push_back(v);
    drain();
    write_reg(pmrc_pkg::REG_MEASURE_LOW, 32'h0010_0000);
    v = '{3, 3, 3, 32'h0004_0000, 1}; pending_vtx.push_back(v);
    drain();
    // zero-width and reversed windows
    run_phase(20, 32'h0002_0000, 32'h0002_0000);
    run_phase(20, 32'h0005_0000, 32'h0001_0000);

    src_idle_pct = 25; snk_idle_pct = 84;
    run_phase(300, 32'hfff0_0000, 32'h0010_0000);
    run_phase(250, 32'h8000_0000, 32'h7fff_ffff);
    src_idle_pct = 84; snk_idle_pct = 25;
    run_phase(300, 32'h0000_0000, 32'h0000_8000);
    run_phase(200, 32'h8000_0000, 32'h8000_0000);
    src_idle_pct = 0; snk_idle_pct = 0;
    hold_cycles = 3000;
    run_phase(400, 32'hffff_0000, 32'h0003_0000);
    run_phase(200, 32'h7fff_ffff, 32'h7fff_ffff);
    run_phase(200, 32'h0010_0000, 32'h0001_0000);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
